@@ src/i2cmbe_pkg.sv @@
// Shared types, constants and helpers for the I2C master line sequencer.
package i2cmbe_pkg;

    // Command codes carried in the operation field
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SEND  = 3'd3,
        OP_READ  = 3'd4,
        OP_SACK  = 3'd5,
        OP_RACK  = 3'd6
    } t_op;

    localparam int unsigned PHASE_W = 5;
    localparam int unsigned BIT_W   = 3;
    localparam logic [7:0]  MSB_MASK = 8'h80;

    // One result transaction, as driven on the master side
    typedef struct packed {
        logic       ack_in;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } t_result;

    // Number of line phases a command occupies
    function automatic logic [PHASE_W-1:0] op_length(input t_op op);
        logic [PHASE_W-1:0] len;
        case (op)
            OP_START: len = 5'd4;
            OP_STOP:  len = 5'd3;
            OP_SEND:  len = 5'd24;
            OP_READ:  len = 5'd17;
            OP_SACK:  len = 5'd3;
            OP_RACK:  len = 5'd3;
            default:  len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

@@ src/i2cmbe_seq.sv @@
// Command sequencer: holds the line state and advances one phase per tick.
module i2cmbe_seq
    import i2cmbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_out,
    input  logic       i_sda_in,
    output t_result    o_result
);

    t_op                r_cmd, n_cmd;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [7:0]         r_shift, n_shift;
    logic               r_ack_seen, n_ack_seen;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic [7:0]         r_tx_hold, n_tx_hold;
    logic               r_ack_hold, n_ack_hold;

    logic               launch;
    t_op                cur_cmd;
    logic [PHASE_W-1:0] cur_phase;
    logic [PHASE_W-1:0] phase_inc;
    logic               done;
    logic [8:0]         send_prod;
    logic [BIT_W-1:0]   send_bit;
    logic [PHASE_W-1:0] send_sub;
    logic [PHASE_W-1:0] read_p;
    logic [BIT_W-1:0]   read_bit;
    logic [7:0]         shift_base;

    // A new command is taken only when idle; the undefined code counts as none
    assign launch    = (r_cmd == OP_NONE) && (i_operation >= OP_START) &&
                       (i_operation <= OP_RACK);
    assign cur_cmd   = launch ? t_op'(i_operation) : r_cmd;
    assign cur_phase = launch ? '0 : r_phase;
    assign phase_inc = cur_phase + 5'd1;

    // Next command state and phase counter
    always_comb begin
        n_cmd   = cur_cmd;
        n_phase = cur_phase;
        done    = 1'b0;
        if (cur_cmd != OP_NONE) begin
            n_phase = phase_inc;
            if (phase_inc >= op_length(cur_cmd)) begin
                n_cmd   = OP_NONE;
                n_phase = '0;
                done    = 1'b1;
            end
        end
    end

    // Send byte: bit = phase / 3 via multiply by 11 and shift by 5 (exact below 24)
    assign send_prod = {4'd0, cur_phase} * 9'd11;
    assign send_bit  = send_prod[7:5];
    assign send_sub  = cur_phase - ({2'd0, send_bit} + {1'b0, send_bit, 1'b0});
    // Read byte: bit pairs after the SDA release phase
    assign read_p    = cur_phase - 5'd1;
    assign read_bit  = read_p[BIT_W:1];
    assign shift_base = (launch && (cur_cmd == OP_READ)) ? 8'd0 : r_shift;

    // Line drive and capture for the current phase
    always_comb begin
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_shift    = shift_base;
        n_ack_seen = r_ack_seen;
        n_tx_hold  = launch ? i_tx_byte : r_tx_hold;
        n_ack_hold = launch ? i_ack_out : r_ack_hold;
        case (cur_cmd)
            OP_START: begin
                case (cur_phase)
                    5'd0:    n_sda = 1'b1;
                    5'd1:    n_scl = 1'b1;
                    5'd2:    n_sda = 1'b0;
                    default: n_scl = 1'b0;
                endcase
            end
            OP_STOP: begin
                case (cur_phase)
                    5'd0:    n_sda = 1'b0;
                    5'd1:    n_scl = 1'b1;
                    default: n_sda = 1'b1;
                endcase
            end
            OP_SEND: begin
                case (send_sub)
                    5'd0:    n_sda = |(n_tx_hold & (MSB_MASK >> send_bit));
                    5'd1:    n_scl = 1'b1;
                    default: n_scl = 1'b0;
                endcase
            end
            OP_READ: begin
                if (cur_phase == 5'd0) begin
                    n_sda = 1'b1;
                end else if (!read_p[0]) begin
                    n_scl = 1'b1;
                    if (i_sda_in) begin
                        n_shift = shift_base | (MSB_MASK >> read_bit);
                    end
                end else begin
                    n_scl = 1'b0;
                end
            end
            OP_SACK: begin
                case (cur_phase)
                    5'd0:    n_sda = n_ack_hold;
                    5'd1:    n_scl = 1'b1;
                    default: n_scl = 1'b0;
                endcase
            end
            OP_RACK: begin
                case (cur_phase)
                    5'd0: n_sda = 1'b1;
                    5'd1: begin
                        n_scl      = 1'b1;
                        n_ack_seen = i_sda_in;
                    end
                    default: n_scl = 1'b0;
                endcase
            end
            default: ;
        endcase
    end

    // State registers advance once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= OP_NONE;
            r_phase    <= '0;
            r_shift    <= '0;
            r_ack_seen <= 1'b1;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
            r_tx_hold  <= '0;
            r_ack_hold <= 1'b0;
        end else if (i_step) begin
            r_cmd      <= n_cmd;
            r_phase    <= n_phase;
            r_shift    <= n_shift;
            r_ack_seen <= n_ack_seen;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_tx_hold  <= n_tx_hold;
            r_ack_hold <= n_ack_hold;
        end
    end

    // Result of this tick, from the next state
    always_comb begin
        o_result.scl_level = n_scl;
        o_result.sda_level = n_sda;
        o_result.busy_res  = (n_cmd != OP_NONE);
        o_result.done_res  = done;
        o_result.rx_byte   = n_shift;
        o_result.ack_in    = n_ack_seen;
    end

endmodule

@@ src/i2c_master_bit_engine_core.sv @@
// A result is registered and appears on the master side in the cycle after its tick
// is accepted. Throughput: one tick per cycle unless a result stalls; the output
// register refills in the cycle it is taken. The sequencer state advances one line
// phase per accepted tick. Reset (synchronous, active low): idle, lines released,
// rx byte 0, ack seen 1, output register empty.
module i2c_master_bit_engine_core
    import i2cmbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[2:0], tx_byte[10:3], ack_out[11], sda_in[12], zero[15:13]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4],
    // ack_in[12], zero[15:13]
    output logic [15:0] m_axis_tdata
);

    logic    step;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    // Take a tick whenever the output register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    i2cmbe_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_operation (s_axis_tdata[2:0]),
        .i_tx_byte   (s_axis_tdata[10:3]),
        .i_ack_out   (s_axis_tdata[11]),
        .i_sda_in    (s_axis_tdata[12]),
        .o_result    (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.ack_in, r_out.rx_byte, r_out.done_res,
                            r_out.busy_res, r_out.sda_level, r_out.scl_level};

endmodule

@@ src/i2cmbe_chk.sv @@
// Port-level checker for the sequencer core, bound to the top level.
module i2cmbe_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // Every accepted tick shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

    // A stalled result blocks the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

    // A finishing command never reports busy in the same result
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[2]))
        else $error("done and busy both set");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // Result padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:13] == 3'd0))
        else $error("result padding not zero");

endmodule

bind i2c_master_bit_engine_core i2cmbe_chk u_i2cmbe_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
